// ===== rtl/mips_branch_and_access_decode_assert.svh =====
// Assertion macros for the MIPS branch and access decoder.
// Used by the top level; relies on clk and rst in the including scope.
`ifndef MIPS_BRANCH_AND_ACCESS_DECODE_ASSERT_SVH
`define MIPS_BRANCH_AND_ACCESS_DECODE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MBAD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");
`define MBAD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");
`else
`define MBAD_ASSERT_IMP(label, ante, cons)
`define MBAD_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== rtl/mbad_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, opcode constants and helpers for the MIPS branch and access decoder.
// No dependencies.
package mbad_pkg;

  localparam int IN_DATA_W  = 200;
  localparam int OUT_DATA_W = 80;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_COP0    = 6'h10;
  localparam logic [5:0] OP_BEQL    = 6'h14;
  localparam logic [5:0] OP_BNEL    = 6'h15;
  localparam logic [5:0] OP_BLEZL   = 6'h16;
  localparam logic [5:0] OP_BGTZL   = 6'h17;
  localparam logic [5:0] OP_LDL     = 6'h1A;
  localparam logic [5:0] OP_LDR     = 6'h1B;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LWL     = 6'h22;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_LWR     = 6'h26;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SWL     = 6'h2A;
  localparam logic [5:0] OP_SW      = 6'h2B;
  localparam logic [5:0] OP_SDL     = 6'h2C;
  localparam logic [5:0] OP_SDR     = 6'h2D;
  localparam logic [5:0] OP_SWR     = 6'h2E;
  localparam logic [5:0] OP_LD      = 6'h37;
  localparam logic [5:0] OP_SD      = 6'h3F;

  // special function codes
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_ERET    = 6'h18;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;

  localparam logic [4:0] RS_CO      = 5'h10;

  localparam logic [31:0] SYSCALL_VECTOR = 32'h8000_0180;

  typedef struct packed {
    logic [31:0] instruction_word;
    logic [31:0] pc_address;
    logic        address_valid;
    logic [31:0] rs_value;
    logic [31:0] rt_value;
    logic        error_level;
    logic [31:0] exception_pc;
    logic [31:0] error_exception_pc;
  } in_item_t;

  typedef struct packed {
    logic        is_branch;
    logic        is_linked;
    logic        is_likely;
    logic        to_register;
    logic        is_conditional;
    logic        condition_met;
    logic [31:0] target_address;
    logic        is_data_access;
    logic [3:0]  access_size;
    logic        has_relevant_address;
    logic [31:0] relevant_address;
    logic        is_syscall;
  } out_item_t;

  // sign-extend the 16-bit immediate of an instruction word
  function automatic logic [31:0] sext16(input logic [31:0] word);
    return {{16{word[15]}}, word[15:0]};
  endfunction

endpackage

// ===== rtl/mbad_decode.sv =====
`timescale 1ns / 1ps
// Combinational decode of one instruction: branch flags, targets and access address.
// Depends on mbad_pkg.
module mbad_decode (
  input  mbad_pkg::in_item_t  item,
  output mbad_pkg::out_item_t res
);
  import mbad_pkg::*;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_JUMP   = 2'd1;
  localparam logic [1:0] KIND_BRANCH = 2'd2;

  logic [5:0]  opn;
  logic [4:0]  rsf;
  logic [4:0]  rtf;
  logic [5:0]  fn;
  logic [31:0] imm;
  logic [31:0] rsv;
  logic [31:0] rtv;
  logic [1:0]  kind;
  logic [2:0]  off;

  assign opn = item.instruction_word[31:26];
  assign rsf = item.instruction_word[25:21];
  assign rtf = item.instruction_word[20:16];
  assign fn  = item.instruction_word[5:0];
  assign imm = sext16(item.instruction_word);
  assign rsv = item.rs_value;
  assign rtv = item.rt_value;

  always_comb begin
    res  = '0;
    kind = KIND_NONE;
    off  = 3'd0;
    if (item.address_valid) begin
      // branch and jump classification
      case (opn)
        OP_SPECIAL: begin
          if (fn == FN_JR) begin
            kind = KIND_JUMP;
            res.to_register = 1'b1;
          end else if (fn == FN_JALR) begin
            kind = KIND_JUMP;
            res.to_register = 1'b1;
            res.is_linked = 1'b1;
          end
        end
        OP_REGIMM: begin
          if (rtf[3:2] == 2'b00) begin
            kind = KIND_BRANCH;
            res.condition_met = rtf[0] ? !rsv[31] : rsv[31];
            res.is_likely = rtf[1];
            res.is_linked = rtf[4];
          end
        end
        OP_J: kind = KIND_JUMP;
        OP_JAL: begin
          kind = KIND_JUMP;
          res.is_linked = 1'b1;
        end
        OP_BEQ, OP_BEQL: begin
          kind = KIND_BRANCH;
          res.condition_met = (rsv == rtv);
          res.is_likely = opn[4];
        end
        OP_BNE, OP_BNEL: begin
          kind = KIND_BRANCH;
          res.condition_met = (rsv != rtv);
          res.is_likely = opn[4];
        end
        OP_BLEZ, OP_BLEZL: begin
          kind = KIND_BRANCH;
          res.condition_met = rsv[31] || (rsv == 32'd0);
          res.is_likely = opn[4];
        end
        OP_BGTZ, OP_BGTZL: begin
          kind = KIND_BRANCH;
          res.condition_met = !rsv[31] && (rsv != 32'd0);
          res.is_likely = opn[4];
        end
        default: ;
      endcase

      if (kind != KIND_NONE) begin
        // branch or jump: flags and target only
        res.is_branch = 1'b1;
        res.is_conditional = (kind == KIND_BRANCH);
        if ((opn[3:0] == OP_BEQ[3:0] || opn[3:0] == OP_BNE[3:0]) && rsf == rtf) begin
          res.is_conditional = 1'b0;
        end
        if (kind == KIND_JUMP) begin
          res.target_address = res.to_register ? rsv :
              {item.pc_address[31:28], item.instruction_word[25:0], 2'b00};
        end else begin
          res.target_address = item.pc_address + 32'd4 + {imm[29:0], 2'b00};
        end
      end else begin
        // load and store sizes, with the unaligned-left offsets
        case (opn) inside
          OP_LB, OP_LBU, OP_SB:          res.access_size = 4'd1;
          OP_LH, OP_LHU, OP_SH:          res.access_size = 4'd2;
          OP_LW, OP_LWR, OP_SW, OP_SWR:  res.access_size = 4'd4;
          OP_LWL, OP_SWL: begin
            res.access_size = 4'd4;
            off = 3'd3;
          end
          OP_LD, OP_LDR, OP_SD, OP_SDR:  res.access_size = 4'd8;
          OP_LDL, OP_SDL: begin
            res.access_size = 4'd8;
            off = 3'd7;
          end
          default: ;
        endcase

        if (res.access_size != 4'd0) begin
          res.is_data_access = 1'b1;
          res.has_relevant_address = 1'b1;
          res.relevant_address = rsv + imm - {29'd0, off};
        end else if (opn == OP_SPECIAL) begin
          // syscall and register alu ops
          if (fn == FN_SYSCALL) begin
            res.is_syscall = 1'b1;
            res.target_address = SYSCALL_VECTOR;
          end else if (fn == FN_ADD || fn == FN_ADDU) begin
            res.has_relevant_address = 1'b1;
            res.relevant_address = rsv + rtv;
          end else if (fn == FN_SUB || fn == FN_SUBU) begin
            res.has_relevant_address = 1'b1;
            res.relevant_address = rsv - rtv;
          end
        end else if (opn == OP_ADDI || opn == OP_ADDIU) begin
          res.has_relevant_address = 1'b1;
          res.relevant_address = rsv + imm;
        end else if (opn == OP_COP0 && rsf == RS_CO && fn == FN_ERET) begin
          // eret returns through EPC or ErrorEPC
          res.is_branch = 1'b1;
          res.target_address = item.error_level ? item.error_exception_pc : item.exception_pc;
        end
      end
    end
  end

endmodule

// ===== rtl/mips_branch_and_access_decode.sv =====
`timescale 1ns / 1ps
// MIPS branch-target and load/store-address decoder, top level.
// Depends on mbad_pkg, mbad_decode and mips_branch_and_access_decode_assert.svh.
//
// Takes one instruction item per clock and returns one result item for each:
// an input register feeds a single pass of decode logic (one 32-bit add
// chain and compares) into a result register. Sustained rate is one item
// per cycle; the result register lets a new item be taken while a finished
// result waits on m_axis_tready, and the input side stalls only once both
// registers hold items. An item whose address_valid flag is clear yields a
// result of all zeros.
`include "mips_branch_and_access_decode_assert.svh"

module mips_branch_and_access_decode (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // instruction_word, pc_address, rs_value, rt_value, error_level,
  // exception_pc, error_exception_pc, zero fill
  input  logic [mbad_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // address_valid
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // is_branch, is_linked, is_likely, to_register, is_conditional,
  // condition_met, target_address, is_data_access, access_size,
  // has_relevant_address, relevant_address, is_syscall, zero fill
  output logic [mbad_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import mbad_pkg::*;

  in_item_t  in_item;
  in_item_t  in_q;
  logic      in_valid;
  out_item_t res;
  out_item_t out_q;
  logic      out_valid;
  logic      in_accept;
  logic      in_advance;

  // unpack the input item
  always_comb begin
    in_item.instruction_word   = s_axis_tdata[31:0];
    in_item.pc_address         = s_axis_tdata[63:32];
    in_item.rs_value           = s_axis_tdata[95:64];
    in_item.rt_value           = s_axis_tdata[127:96];
    in_item.error_level        = s_axis_tdata[128];
    in_item.exception_pc       = s_axis_tdata[160:129];
    in_item.error_exception_pc = s_axis_tdata[192:161];
    in_item.address_valid      = s_axis_tuser;
  end

  // handshake between the two register stages
  assign in_advance    = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || in_advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid <= 1'b1;
      end else if (in_advance) begin
        in_valid <= 1'b0;
      end
      if (in_advance) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_q <= in_item;
    end
    if (in_advance) begin
      out_q <= res;
    end
  end

  mbad_decode u_decode (
    .item (in_q),
    .res  (res)
  );

  // pack the result item
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_q.is_syscall, out_q.relevant_address,
                          out_q.has_relevant_address, out_q.access_size,
                          out_q.is_data_access, out_q.target_address,
                          out_q.condition_met, out_q.is_conditional,
                          out_q.to_register, out_q.is_likely, out_q.is_linked,
                          out_q.is_branch};

  // checks
  `MBAD_ASSERT_IMP(a_branch_not_access, out_valid && out_q.is_branch, !out_q.is_data_access && !out_q.has_relevant_address)
  `MBAD_ASSERT_IMP(a_size_matches_access, out_valid, out_q.is_data_access == (out_q.access_size != 4'd0))
  `MBAD_ASSERT_IMP(a_syscall_vector, out_valid && out_q.is_syscall, out_q.target_address == SYSCALL_VECTOR && !out_q.is_branch)
  `MBAD_ASSERT_NXT(a_advance_fills_output, in_valid && !out_valid, out_valid)

endmodule
